// ===== src/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg: shared constants and types for the LFU cache
// Slot geometry, field widths, command codes and the slot access structs.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int RANK_W     = IDX_W;
  localparam int OCC_W      = $clog2(ENTRIES + 1);
  localparam int COUNT_BITS = 16;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int CAP_W      = 5;
  localparam int CMP_W      = (CAP_W > OCC_W) ? CAP_W : OCC_W;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [CAP_W-1:0]      CAP_RESET  = CAP_W'(16);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
  localparam logic [VAL_W-1:0]      MISS_VALUE = {VAL_W{1'b1}};

  // register index (byte address / 4)
  localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                  valid;
    logic [KEY_W-1:0]      key;
    logic [VAL_W-1:0]      value;
    logic [COUNT_BITS-1:0] count;
    logic [RANK_W-1:0]     rank;
  } slot_rd_t;

  typedef struct packed {
    logic [IDX_W-1:0]      idx;
    logic                  set_entry;  // marks valid, writes key
    logic                  set_value;
    logic                  set_count;
    logic                  set_rank;
    logic [KEY_W-1:0]      key;
    logic [VAL_W-1:0]      value;
    logic [COUNT_BITS-1:0] count;
    logic [RANK_W-1:0]     rank;
  } slot_wr_t;

endpackage

// ===== src/lfu_req_if.sv =====
// ----------------------------------------------------------------------------
// lfu_req_if: request channel of the LFU cache
// Valid/ready handshake carrying command, key and write value.
// ----------------------------------------------------------------------------
interface lfu_req_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [lfu_pkg::KEY_W-1:0]           lookup_key;
  logic signed [lfu_pkg::VAL_W-1:0]    write_value;

  modport source (output valid, cmd, lookup_key, write_value, input ready);
  modport sink   (input valid, cmd, lookup_key, write_value, output ready);
endinterface

// ===== src/lfu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lfu_rsp_if: response channel of the LFU cache
// Valid/ready handshake carrying hit flag and read value.
// ----------------------------------------------------------------------------
interface lfu_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic signed [lfu_pkg::VAL_W-1:0]    read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

// ===== src/lfu_cfg.sv =====
// ----------------------------------------------------------------------------
// lfu_cfg: APB register block
// Holds the capacity register; writes complete in the access phase.
// ----------------------------------------------------------------------------
module lfu_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfu_pkg::ADDR_W-1:0]   paddr,
  input  logic [lfu_pkg::DATA_W-1:0]   pwdata,
  output logic [lfu_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [lfu_pkg::CAP_W-1:0]    capacity_o
);

  logic [lfu_pkg::CAP_W-1:0] capacity_q;
  logic                      sel_cap;

  assign pready     = 1'b1;
  assign sel_cap    = (paddr[lfu_pkg::ADDR_W-1:2] == lfu_pkg::REG_CAPACITY);
  assign capacity_o = capacity_q;

  always_comb begin
    prdata = '0;
    if (sel_cap) begin
      prdata = lfu_pkg::DATA_W'(capacity_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= lfu_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && sel_cap) begin
      capacity_q <= pwdata[lfu_pkg::CAP_W-1:0];
    end
  end

endmodule

// ===== src/lfu_slots.sv =====
// ----------------------------------------------------------------------------
// lfu_slots: slot register file
// Valid bits, keys, values, use counts and recency ranks; one read index,
// one write index per cycle.
// ----------------------------------------------------------------------------
module lfu_slots (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lfu_pkg::IDX_W-1:0]   rd_idx_i,
  output lfu_pkg::slot_rd_t           rd_o,
  input  lfu_pkg::slot_wr_t           wr_i
);

  logic [lfu_pkg::ENTRIES-1:0]    valid_q;
  logic [lfu_pkg::KEY_W-1:0]      key_q   [lfu_pkg::ENTRIES];
  logic [lfu_pkg::VAL_W-1:0]      value_q [lfu_pkg::ENTRIES];
  logic [lfu_pkg::COUNT_BITS-1:0] count_q [lfu_pkg::ENTRIES];
  logic [lfu_pkg::RANK_W-1:0]     rank_q  [lfu_pkg::ENTRIES];

  always_comb begin
    rd_o.valid = valid_q[rd_idx_i];
    rd_o.key   = key_q[rd_idx_i];
    rd_o.value = value_q[rd_idx_i];
    rd_o.count = count_q[rd_idx_i];
    rd_o.rank  = rank_q[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.set_entry) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.set_entry) begin
      key_q[wr_i.idx] <= wr_i.key;
    end
    if (wr_i.set_value) begin
      value_q[wr_i.idx] <= wr_i.value;
    end
    if (wr_i.set_count) begin
      count_q[wr_i.idx] <= wr_i.count;
    end
    if (wr_i.set_rank) begin
      rank_q[wr_i.idx] <= wr_i.rank;
    end
  end

endmodule

// ===== src/lfu_seq.sv =====
// ----------------------------------------------------------------------------
// lfu_seq: request sequencer
// Scans the slots one per cycle through a shared key/victim compare, applies
// the update, then, if a slot changed, walks them again to age recency ranks.
// ----------------------------------------------------------------------------
module lfu_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lfu_pkg::CAP_W-1:0]   capacity_i,
  lfu_req_if.sink                     req,
  lfu_rsp_if.source                   rsp,
  output logic [lfu_pkg::IDX_W-1:0]   rd_idx_o,
  input  lfu_pkg::slot_rd_t           rd_i,
  output lfu_pkg::slot_wr_t           wr_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RANK,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_HIT,
    ACT_EVICT,
    ACT_FILL
  } act_e;

  state_e                         state_q;
  logic [lfu_pkg::IDX_W-1:0]      idx_q;
  logic                           cmd_q;
  logic [lfu_pkg::KEY_W-1:0]      key_q;
  logic [lfu_pkg::VAL_W-1:0]      val_q;
  logic                           found_q;
  logic [lfu_pkg::IDX_W-1:0]      found_idx_q;
  logic [lfu_pkg::VAL_W-1:0]      found_val_q;
  logic [lfu_pkg::COUNT_BITS-1:0] found_cnt_q;
  logic [lfu_pkg::RANK_W-1:0]     found_rank_q;
  logic                           vic_q;
  logic [lfu_pkg::IDX_W-1:0]      vic_idx_q;
  logic [lfu_pkg::COUNT_BITS-1:0] vic_cnt_q;
  logic [lfu_pkg::RANK_W-1:0]     vic_rank_q;
  logic                           free_q;
  logic [lfu_pkg::IDX_W-1:0]      free_idx_q;
  logic [lfu_pkg::OCC_W-1:0]      occ_q;
  logic [lfu_pkg::IDX_W-1:0]      tgt_q;
  logic [lfu_pkg::OCC_W-1:0]      old_rank_q;
  logic                           hit_q;
  logic [lfu_pkg::VAL_W-1:0]      rdval_q;
  logic                           out_valid_q;
  logic                           out_hit_q;
  logic [lfu_pkg::VAL_W-1:0]      out_val_q;

  logic                           match;
  logic                           better;
  logic                           last;
  logic [lfu_pkg::COUNT_BITS-1:0] bumped;
  logic [lfu_pkg::CMP_W-1:0]      cap_ext;
  logic [lfu_pkg::CMP_W-1:0]      cap_eff;
  logic                           cap_zero;
  logic                           occ_full;
  act_e                           act;

  assign req.ready      = (state_q == ST_IDLE);
  assign rsp.valid      = out_valid_q;
  assign rsp.hit        = out_hit_q;
  assign rsp.read_value = $signed(out_val_q);
  assign rd_idx_o       = idx_q;

  always_comb begin
    match  = rd_i.valid && (rd_i.key == key_q);
    // lower count wins; equal counts go to the older entry
    better = rd_i.valid && (!vic_q || (rd_i.count < vic_cnt_q) ||
             ((rd_i.count == vic_cnt_q) && (rd_i.rank > vic_rank_q)));
    last   = (idx_q == lfu_pkg::IDX_W'(lfu_pkg::ENTRIES - 1));
    bumped = (found_cnt_q == lfu_pkg::COUNT_MAX) ? found_cnt_q
                                                 : found_cnt_q + 1'b1;
    cap_ext  = lfu_pkg::CMP_W'(capacity_i);
    cap_eff  = (cap_ext > lfu_pkg::CMP_W'(lfu_pkg::ENTRIES))
               ? lfu_pkg::CMP_W'(lfu_pkg::ENTRIES) : cap_ext;
    cap_zero = (cap_eff == '0);
    occ_full = (lfu_pkg::CMP_W'(occ_q) >= cap_eff);

    act = ACT_NONE;
    if (found_q && ((cmd_q == lfu_pkg::CMD_GET) || !cap_zero)) begin
      act = ACT_HIT;
    end else if (!found_q && (cmd_q == lfu_pkg::CMD_PUT) && !cap_zero) begin
      if (occ_full && vic_q) begin
        act = ACT_EVICT;
      end else if (free_q) begin
        act = ACT_FILL;
      end
    end
  end

  always_comb begin
    wr_o       = '0;
    wr_o.key   = key_q;
    wr_o.value = val_q;
    case (state_q)
      ST_DECIDE: begin
        case (act)
          ACT_HIT: begin
            wr_o.idx       = found_idx_q;
            wr_o.set_count = 1'b1;
            wr_o.count     = bumped;
            wr_o.set_value = (cmd_q == lfu_pkg::CMD_PUT);
          end
          ACT_EVICT, ACT_FILL: begin
            wr_o.idx       = (act == ACT_EVICT) ? vic_idx_q : free_idx_q;
            wr_o.set_entry = 1'b1;
            wr_o.set_value = 1'b1;
            wr_o.set_count = 1'b1;
            wr_o.count     = lfu_pkg::COUNT_ONE;
          end
          default: ;
        endcase
      end
      ST_RANK: begin
        wr_o.idx = idx_q;
        if (idx_q == tgt_q) begin
          wr_o.set_rank = 1'b1;
          wr_o.rank     = '0;
        end else if (rd_i.valid && (lfu_pkg::OCC_W'(rd_i.rank) < old_rank_q)) begin
          wr_o.set_rank = 1'b1;
          wr_o.rank     = rd_i.rank + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      found_q     <= 1'b0;
      vic_q       <= 1'b0;
      free_q      <= 1'b0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // ST_RESP reloads the response register itself
      if (out_valid_q && rsp.ready && (state_q != ST_RESP)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req.valid) begin
            cmd_q   <= req.cmd;
            key_q   <= req.lookup_key;
            val_q   <= req.write_value;
            found_q <= 1'b0;
            vic_q   <= 1'b0;
            free_q  <= 1'b0;
            idx_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (match && !found_q) begin
            found_q      <= 1'b1;
            found_idx_q  <= idx_q;
            found_val_q  <= rd_i.value;
            found_cnt_q  <= rd_i.count;
            found_rank_q <= rd_i.rank;
          end
          if (better) begin
            vic_q      <= 1'b1;
            vic_idx_q  <= idx_q;
            vic_cnt_q  <= rd_i.count;
            vic_rank_q <= rd_i.rank;
          end
          if (!rd_i.valid && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= idx_q;
          end
          if (last) begin
            idx_q   <= '0;
            state_q <= ST_DECIDE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_DECIDE: begin
          hit_q   <= found_q;
          rdval_q <= (found_q && (cmd_q == lfu_pkg::CMD_GET)) ? found_val_q
                                                              : lfu_pkg::MISS_VALUE;
          idx_q   <= '0;
          unique case (act)
            ACT_HIT: begin
              tgt_q      <= found_idx_q;
              old_rank_q <= lfu_pkg::OCC_W'(found_rank_q);
              state_q    <= ST_RANK;
            end
            ACT_EVICT: begin
              tgt_q      <= vic_idx_q;
              old_rank_q <= lfu_pkg::OCC_W'(vic_rank_q);
              state_q    <= ST_RANK;
            end
            ACT_FILL: begin
              tgt_q      <= free_idx_q;
              old_rank_q <= occ_q;
              occ_q      <= occ_q + 1'b1;
              state_q    <= ST_RANK;
            end
            default: begin
              state_q <= ST_RESP;
            end
          endcase
        end
        ST_RANK: begin
          if (last) begin
            idx_q   <= '0;
            state_q <= ST_RESP;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_RESP: begin
          if (!out_valid_q || rsp.ready) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= hit_q;
            out_val_q   <= rdval_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= lfu_pkg::OCC_W'(lfu_pkg::ENTRIES))
    else $error("occupancy above slot count");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> (state_q == ST_SCAN) && (idx_q == '0))
    else $error("accepted request did not start a scan at slot zero");

  a_target_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RANK && idx_q == tgt_q) |-> (wr_o.set_rank && wr_o.rank == '0))
    else $error("touched slot not made most recent");

  a_fill_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && act == ACT_FILL) |-> (free_q && !occ_full))
    else $error("fill without a free slot below capacity");
`endif

endmodule

// ===== src/lfu_cache.sv =====
// ----------------------------------------------------------------------------
// lfu_cache: least-frequently-used key/value cache, LRU tiebreak
//
//   channel  | dir  | handshake             | content
//   ---------+------+-----------------------+-------------------------------
//   req_if   | in   | valid/ready           | cmd, lookup_key, write_value
//   rsp_if   | out  | valid/ready           | hit, read_value
//   apb      | in   | psel/penable, pready  | cache_capacity at address 0
//
// From acceptance to response valid, a request passes the lookup/victim scan
// (one slot per cycle through the shared compare unit), the update, rank
// aging (one slot per cycle) and the response state. A request that changes
// no slot (get miss, put with capacity zero) skips rank aging.
// req ready is high only when idle, so a new request is accepted only after
// the previous one has left the response state.
// The response register holds a result until taken; the next request is
// accepted meanwhile, and its response waits until the register is free.
// Reset clears valid bits and occupancy, no sweep.
// ----------------------------------------------------------------------------
module lfu_cache (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lfu_req_if.sink                      req_if,
  lfu_rsp_if.source                    rsp_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfu_pkg::ADDR_W-1:0]   paddr,
  input  logic [lfu_pkg::DATA_W-1:0]   pwdata,
  output logic [lfu_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [lfu_pkg::CAP_W-1:0] capacity;
  logic [lfu_pkg::IDX_W-1:0] rd_idx;
  lfu_pkg::slot_rd_t         slot_rd;
  lfu_pkg::slot_wr_t         slot_wr;

  lfu_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  lfu_slots u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .rd_o     (slot_rd),
    .wr_i     (slot_wr)
  );

  lfu_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .capacity_i (capacity),
    .req        (req_if),
    .rsp        (rsp_if),
    .rd_idx_o   (rd_idx),
    .rd_i       (slot_rd),
    .wr_o       (slot_wr)
  );

endmodule
